/* hw/rtl/z80_alu_with_flags_macros.svh */
// Assertion macros shared by the RTL of the Z80 ALU block.
`ifndef Z80_ALU_WITH_FLAGS_MACROS_SVH
`define Z80_ALU_WITH_FLAGS_MACROS_SVH

// Checked on every rising edge of clk_i once reset has been released.
`define Z80AF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define Z80AF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/z80af_pkg.sv */
// Package for the Z80 ALU block: field widths, operation codes and flag constants.
`default_nettype none

package z80af_pkg;

  localparam int unsigned OP_W   = 5;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned FLAG_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLCA  = 5'd10,
    OP_RRCA  = 5'd11,
    OP_RLA   = 5'd12,
    OP_RRA   = 5'd13,
    OP_DAA   = 5'd14,
    OP_CPL   = 5'd15,
    OP_SCF   = 5'd16,
    OP_CCF   = 5'd17,
    OP_ADD16 = 5'd18
  } alu_op_e;

  // Flag byte bit positions: S Z 5 H 3 P/V N C.
  localparam int unsigned FLAG_S  = 7;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_Y  = 5;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_X  = 3;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_N  = 1;
  localparam int unsigned FLAG_C  = 0;

  // Masks of flags that pass through unchanged (KEEP_*), of bits 5 and 3, and of H and N to set.
  localparam logic [FLAG_W-1:0] KEEP_SZPV   = 8'hc4;
  localparam logic [FLAG_W-1:0] KEEP_SZPVC  = 8'hc5;
  localparam logic [FLAG_W-1:0] MASK_53     = 8'h28;
  localparam logic [FLAG_W-1:0] SET_HN      = 8'h12;

  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [7:0] DAA_HI    = 8'h60;

endpackage

`default_nettype wire

/* hw/rtl/z80_alu_with_flags.sv */
// Top level of the Z80 ALU block: input register, flag logic and result register.
//
//   Channel  Direction  Handshake                   Payload
//   request  in         in_valid_i / in_stall_o     req_type_i, operand_a_i, operand_b_i,
//                                                   flags_in_i
//   result   out        out_valid_o / out_stall_i   result_value_o, flags_out_o
//
// Each word passes through two registers: it is captured in the input register,
// the whole ALU and flag computation is done combinationally between the two
// registers, and the result register presents it. A new word can be taken in every
// cycle while the output is not stalled, so the throughput is one word per cycle.
// The reset is asynchronous and active low; it clears only the valid bits.
// A stalled result is held while the input register keeps its word, and the
// request side is stalled only when both registers are full.
`default_nettype none
`include "z80_alu_with_flags_macros.svh"

module z80_alu_with_flags (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [z80af_pkg::OP_W-1:0]         req_type_i,
  input  logic [z80af_pkg::WORD_W-1:0]       operand_a_i,
  input  logic [z80af_pkg::WORD_W-1:0]       operand_b_i,
  input  logic [z80af_pkg::FLAG_W-1:0]       flags_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [z80af_pkg::WORD_W-1:0]       result_value_o,
  output logic [z80af_pkg::FLAG_W-1:0]       flags_out_o
);

  import z80af_pkg::*;

  // Input register.
  logic                s1_valid_q;
  logic [OP_W-1:0]     s1_op_q;
  logic [WORD_W-1:0]   s1_a_q;
  logic [WORD_W-1:0]   s1_b_q;
  logic [FLAG_W-1:0]   s1_f_q;

  // Result register.
  logic                out_valid_q;
  logic [WORD_W-1:0]   result_value_q;
  logic [FLAG_W-1:0]   flags_out_q;
  logic [WORD_W-1:0]   result_value_d;
  logic [FLAG_W-1:0]   flags_out_d;

  logic s2_ready;
  logic s1_ready;
  logic in_accept;
  logic s2_load;

  // The result register can take a word when empty or when its word leaves now.
  assign s2_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign in_accept = in_valid_i && s1_ready;
  assign s2_load   = s1_valid_q && s2_ready;

  assign in_stall_o     = !s1_ready;
  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_value_q;
  assign flags_out_o    = flags_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s2_ready) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q <= req_type_i;
      s1_a_q  <= operand_a_i;
      s1_b_q  <= operand_b_i;
      s1_f_q  <= flags_in_i;
    end
    if (s2_load) begin
      result_value_q <= result_value_d;
      flags_out_q    <= flags_out_d;
    end
  end

  // Shared 8-bit adder/subtractor, used by the arithmetic group, CP and DAA.
  logic [7:0] acc;
  logic [7:0] opnd;
  logic       cin;
  logic [7:0] ar_b;
  logic       ar_c;
  logic       ar_sub;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_bc;
  logic [8:0] sub_diff;
  logic [7:0] ar_r;
  logic       ar_h;
  logic       ar_v;
  logic       ar_cy;

  assign acc  = s1_a_q[7:0];
  assign opnd = s1_b_q[7:0];
  assign cin  = s1_f_q[FLAG_C];

  // DAA correction: low nibble above nine or half carry, and value above 0x99 or carry.
  logic       daa_big;
  logic [7:0] daa_adj;

  assign daa_big = (acc > DAA_LIMIT);
  assign daa_adj = ((s1_f_q[FLAG_H] || (acc[3:0] > 4'd9)) ? DAA_LO : 8'h00)
                 | ((cin || daa_big) ? DAA_HI : 8'h00);

  always_comb begin
    ar_b   = opnd;
    ar_c   = 1'b0;
    ar_sub = 1'b0;
    case (s1_op_q)
      OP_ADC: begin
        ar_c = cin;
      end
      OP_SUB, OP_CP: begin
        ar_sub = 1'b1;
      end
      OP_SBC: begin
        ar_sub = 1'b1;
        ar_c   = cin;
      end
      OP_DAA: begin
        ar_b   = daa_adj;
        ar_sub = s1_f_q[FLAG_N];
      end
      default: begin
        ar_b = opnd;
      end
    endcase
  end

  assign add_sum  = {1'b0, acc} + {1'b0, ar_b} + {8'h00, ar_c};
  assign add_half = {1'b0, acc[3:0]} + {1'b0, ar_b[3:0]} + {4'h0, ar_c};
  assign sub_bc   = {1'b0, ar_b} + {8'h00, ar_c};
  assign sub_diff = {1'b0, acc} - sub_bc;

  always_comb begin
    if (ar_sub) begin
      ar_r  = sub_diff[7:0];
      ar_h  = acc[4] ^ ar_b[4] ^ sub_diff[4];
      ar_v  = (acc[7] ^ ar_b[7]) & (acc[7] ^ sub_diff[7]);
      ar_cy = ({1'b0, acc} < sub_bc);
    end else begin
      ar_r  = add_sum[7:0];
      ar_h  = add_half[4];
      ar_v  = ~(acc[7] ^ ar_b[7]) & (acc[7] ^ add_sum[7]);
      ar_cy = add_sum[8];
    end
  end

  // 16-bit add.
  logic [16:0] add16_sum;
  logic [12:0] add16_half;

  assign add16_sum  = {1'b0, s1_a_q} + {1'b0, s1_b_q};
  assign add16_half = {1'b0, s1_a_q[11:0]} + {1'b0, s1_b_q[11:0]};

  // Result selection and flag assembly.
  always_comb begin
    logic [7:0] r8;
    r8             = acc;
    result_value_d = s1_a_q;
    flags_out_d    = s1_f_q;
    case (s1_op_q)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
        r8          = ar_r;
        flags_out_d = {r8[7], (r8 == 8'h00), r8[5], ar_h, r8[3], ar_v, ar_sub, ar_cy};
      end
      OP_CP: begin
        // The undocumented bits follow the operand, not the difference.
        r8          = acc;
        flags_out_d = {ar_r[7], (ar_r == 8'h00), opnd[5], ar_h, opnd[3], ar_v, 1'b1, ar_cy};
      end
      OP_AND: begin
        r8          = acc & opnd;
        flags_out_d = {r8[7], (r8 == 8'h00), r8[5], 1'b1, r8[3], ~^r8, 1'b0, 1'b0};
      end
      OP_XOR: begin
        r8          = acc ^ opnd;
        flags_out_d = {r8[7], (r8 == 8'h00), r8[5], 1'b0, r8[3], ~^r8, 1'b0, 1'b0};
      end
      OP_OR: begin
        r8          = acc | opnd;
        flags_out_d = {r8[7], (r8 == 8'h00), r8[5], 1'b0, r8[3], ~^r8, 1'b0, 1'b0};
      end
      OP_INC: begin
        r8          = acc + 8'h01;
        flags_out_d = {r8[7], (r8 == 8'h00), r8[5], (acc[3:0] == 4'hf), r8[3],
                       (r8 == 8'h80), 1'b0, cin};
      end
      OP_DEC: begin
        r8          = acc - 8'h01;
        flags_out_d = {r8[7], (r8 == 8'h00), r8[5], (acc[3:0] == 4'h0), r8[3],
                       (r8 == 8'h7f), 1'b1, cin};
      end
      OP_RLCA: begin
        r8          = {acc[6:0], acc[7]};
        flags_out_d = (s1_f_q & KEEP_SZPV) | (r8 & MASK_53) | {7'h00, acc[7]};
      end
      OP_RRCA: begin
        r8          = {acc[0], acc[7:1]};
        flags_out_d = (s1_f_q & KEEP_SZPV) | (r8 & MASK_53) | {7'h00, acc[0]};
      end
      OP_RLA: begin
        r8          = {acc[6:0], cin};
        flags_out_d = (s1_f_q & KEEP_SZPV) | (r8 & MASK_53) | {7'h00, acc[7]};
      end
      OP_RRA: begin
        r8          = {cin, acc[7:1]};
        flags_out_d = (s1_f_q & KEEP_SZPV) | (r8 & MASK_53) | {7'h00, acc[0]};
      end
      OP_DAA: begin
        // Parity replaces overflow, and carry sticks once the value is out of range.
        r8          = ar_r;
        flags_out_d = {r8[7], (r8 == 8'h00), r8[5], ar_h, r8[3], ~^r8, ar_sub,
                       (cin | daa_big)};
      end
      OP_CPL: begin
        r8          = ~acc;
        flags_out_d = (s1_f_q & KEEP_SZPVC) | SET_HN | (r8 & MASK_53);
      end
      OP_SCF: begin
        r8          = acc;
        flags_out_d = (s1_f_q & KEEP_SZPV) | (acc & MASK_53) | 8'h01;
      end
      OP_CCF: begin
        // The old carry moves to half carry and the carry is inverted.
        r8          = acc;
        flags_out_d = (s1_f_q & KEEP_SZPV) | (acc & MASK_53)
                    | {3'b000, cin, 3'b000, ~cin};
      end
      default: begin
        r8 = acc;
      end
    endcase

    if (s1_op_q == OP_ADD16) begin
      result_value_d = add16_sum[15:0];
      flags_out_d    = (s1_f_q & KEEP_SZPV) | (add16_sum[15:8] & MASK_53)
                     | {3'b000, add16_half[12], 3'b000, add16_sum[16]};
    end else if (s1_op_q <= OP_CCF) begin
      result_value_d = {8'h00, r8};
    end
  end

  // Checks on the pipeline control and the result formatting.
  `Z80AF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q, "result valid during reset")
  `Z80AF_ASSERT(a_stall_only_full, in_stall_o |-> (s1_valid_q && out_valid_q),
                "request stalled while a register is free")
  `Z80AF_ASSERT(a_advance, s2_load |=> out_valid_q, "word lost between the two registers")
  `Z80AF_ASSERT(a_byte_ops_high_zero, (s2_load && (s1_op_q <= OP_CCF)) |=>
                (result_value_q[15:8] == 8'h00), "byte result with a non-zero high byte")
  `Z80AF_ASSERT(a_unused_op_passthrough, (s2_load && (s1_op_q > OP_ADD16)) |=>
                ((result_value_q == $past(s1_a_q)) && (flags_out_q == $past(s1_f_q))),
                "unused operation code altered the word")

endmodule

`default_nettype wire
